// ===== design/mwu_pkg.sv =====
`timescale 1ns / 1ps

package mwu_pkg;

   localparam int unsigned DATA_W     = 32;
   localparam int unsigned CMD_W      = 2;
   localparam int unsigned LR_W       = 31;
   localparam int unsigned VR_W       = 25;
   localparam int unsigned MODE_W     = 2;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 31;

   localparam logic [LR_W-1:0] LR_RESET = 31'd167772;
   localparam logic [VR_W-1:0] VR_RESET = 25'd0;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD   = 2'd0,
      CMD_UPDATE = 2'd1,
      CMD_READ   = 2'd2
   } cmd_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_MOMENTUM = 2'd0,
      MODE_AVERAGED = 2'd1,
      MODE_NESTEROV = 2'd2,
      MODE_PLAIN    = 2'd3
   } mode_type;

   localparam logic [CSR_IDX_W-1:0] CSR_LEARN_RATE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MOMENTUM_RATE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_UPDATE_MODE   = 2'd2;

   typedef struct packed {
      logic [LR_W-1:0] learn_rate;
      logic [VR_W-1:0] momentum_rate;
      mode_type        update_mode;
   } cfg_type;

endpackage

// ===== design/mwu_ram.sv =====
`timescale 1ns / 1ps

module mwu_ram #(
   parameter int unsigned DEPTH = 512,
   parameter int unsigned WIDTH = 32,
   localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/mwu_pipe.sv =====
`timescale 1ns / 1ps

module mwu_pipe #(
   parameter int unsigned AW        = 9,
   parameter int unsigned FRAC_BITS = 24
) (
   input  logic                            clock,
   input  logic                            reset,
   input  mwu_pkg::cfg_type                cfg,
   input  logic                            in_load,
   input  mwu_pkg::cmd_type                in_cmd,
   input  logic                            in_wr,
   input  logic                            in_oor,
   input  logic [AW-1:0]                   in_addr,
   input  logic signed [mwu_pkg::DATA_W-1:0] in_e,
   input  logic signed [mwu_pkg::DATA_W-1:0] in_s,
   input  logic signed [mwu_pkg::DATA_W-1:0] in_a,
   input  logic signed [mwu_pkg::DATA_W-1:0] in_lv,
   input  logic signed [mwu_pkg::DATA_W-1:0] rd_w,
   input  logic signed [mwu_pkg::DATA_W-1:0] rd_m,
   input  logic [AW-1:0]                   probe_addr,
   output logic                            space,
   output logic                            hit,
   output logic                            wb_en,
   output logic [AW-1:0]                   wb_addr,
   output logic signed [mwu_pkg::DATA_W-1:0] wb_w,
   output logic signed [mwu_pkg::DATA_W-1:0] wb_m,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic signed [mwu_pkg::DATA_W-1:0] out_w,
   output logic signed [mwu_pkg::DATA_W-1:0] out_m
);

   import mwu_pkg::*;

   localparam int unsigned STAGES = 8;
   localparam logic signed [31:0] MAX32 = 32'sh7fff_ffff;
   localparam logic signed [31:0] MIN32 = 32'sh8000_0000;
   localparam logic signed [32:0] ONE33 = 33'sd1 <<< FRAC_BITS;

   typedef struct packed {
      cmd_type            cmd;
      logic               wr;
      logic               oor;
      logic [AW-1:0]      addr;
      logic signed [31:0] e;
      logic signed [31:0] s;
      logic signed [31:0] a;
      logic signed [31:0] lv;
      logic signed [31:0] w;
      logic signed [31:0] m;
      logic signed [31:0] x;
      logic signed [31:0] vm;
      logic signed [31:0] d;
      logic signed [31:0] vel;
   } stage_type;

   function automatic logic signed [32:0] ext(input logic signed [31:0] v);
      return {v[31], v};
   endfunction

   function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
      if (v[32] != v[31]) begin
         return v[32] ? MIN32 : MAX32;
      end
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] fmul(input logic signed [32:0] a,
                                                input logic signed [32:0] b);
      logic signed [65:0] p;
      logic signed [65:0] q;
      p = a * b;
      q = p >>> FRAC_BITS;
      if (!(&q[65:31]) && (|q[65:31])) begin
         return q[65] ? MIN32 : MAX32;
      end
      return q[31:0];
   endfunction

   stage_type          st_ff [STAGES];
   stage_type          st_in [STAGES];
   logic [STAGES-1:0]  v_ff;
   logic [STAGES-1:0]  v_in;
   logic [STAGES:0]    adv;
   logic               out_valid_ff;
   logic signed [31:0] out_w_ff;
   logic signed [31:0] out_m_ff;
   logic signed [31:0] res_w;
   logic signed [31:0] res_m;
   logic signed [32:0] lr_s;
   logic signed [32:0] vr_s;
   logic signed [32:0] coef;
   logic               nest;

   assign lr_s = 33'(cfg.learn_rate);
   assign vr_s = 33'(cfg.momentum_rate);
   assign coef = (cfg.update_mode == MODE_AVERAGED) ? (ONE33 - vr_s) : lr_s;
   assign nest = (cfg.update_mode == MODE_NESTEROV);

   always_comb begin
      adv[STAGES] = !out_valid_ff || out_ready;
      for (int k = STAGES - 1; k >= 0; k--) begin
         adv[k] = !v_ff[k] || adv[k+1];
      end
   end

   assign space = adv[0];

   always_comb begin
      hit = 1'b0;
      for (int k = 0; k < STAGES; k++) begin
         if (v_ff[k] && st_ff[k].wr && (st_ff[k].addr == probe_addr)) begin
            hit = 1'b1;
         end
      end
   end

   always_comb begin
      v_in[0] = in_load;
      for (int k = 1; k < STAGES; k++) begin
         v_in[k] = v_ff[k-1];
      end
   end

   always_comb begin
      st_in[0]      = '0;
      st_in[0].cmd  = in_cmd;
      st_in[0].wr   = in_wr;
      st_in[0].oor  = in_oor;
      st_in[0].addr = in_addr;
      st_in[0].e    = in_e;
      st_in[0].s    = in_s;
      st_in[0].a    = in_a;
      st_in[0].lv   = in_lv;

      st_in[1]    = st_ff[0];
      st_in[1].w  = rd_w;
      st_in[1].m  = rd_m;
      st_in[1].x  = fmul(ext(st_ff[0].e), ext(st_ff[0].s));
      st_in[1].vm = fmul(vr_s, ext(rd_m));

      st_in[2]   = st_ff[1];
      st_in[2].x = fmul(ext(st_ff[1].x), ext(st_ff[1].a));
      st_in[2].d = sat33(ext(st_ff[1].e) - ext(st_ff[1].vm));

      st_in[3] = st_ff[2];
      if (nest) begin
         st_in[3].x = fmul(ext(st_ff[2].d), ext(st_ff[2].s));
      end else begin
         st_in[3].x = fmul(coef, ext(st_ff[2].x));
      end

      st_in[4] = st_ff[3];
      if (nest) begin
         st_in[4].x = fmul(ext(st_ff[3].x), ext(st_ff[3].a));
      end

      st_in[5] = st_ff[4];
      if (nest) begin
         st_in[5].x = fmul(lr_s, ext(st_ff[4].x));
      end

      st_in[6] = st_ff[5];
      if (cfg.update_mode == MODE_MOMENTUM) begin
         st_in[6].vel = sat33(ext(st_ff[5].vm) + ext(st_ff[5].x));
      end else begin
         st_in[6].vel = sat33(ext(st_ff[5].vm) - ext(st_ff[5].x));
      end

      st_in[7] = st_ff[6];
      case (cfg.update_mode)
         MODE_AVERAGED: st_in[7].x = fmul(lr_s, ext(st_ff[6].vel));
         MODE_PLAIN:    st_in[7].x = st_ff[6].x;
         default:       st_in[7].x = st_ff[6].vel;
      endcase
   end

   always_comb begin
      res_w = st_ff[STAGES-1].w;
      res_m = st_ff[STAGES-1].m;
      case (st_ff[STAGES-1].cmd)
         CMD_LOAD: begin
            res_w = st_ff[STAGES-1].lv;
            res_m = '0;
         end
         CMD_UPDATE: begin
            if (cfg.update_mode == MODE_PLAIN) begin
               res_w = sat33(ext(st_ff[STAGES-1].w) + ext(st_ff[STAGES-1].x));
            end else begin
               res_w = sat33(ext(st_ff[STAGES-1].w) - ext(st_ff[STAGES-1].x));
               res_m = st_ff[STAGES-1].vel;
            end
         end
         default: begin
            res_w = st_ff[STAGES-1].w;
            res_m = st_ff[STAGES-1].m;
         end
      endcase
      if (st_ff[STAGES-1].oor) begin
         res_w = '0;
         res_m = '0;
      end
   end

   assign wb_en   = adv[STAGES] && v_ff[STAGES-1] && st_ff[STAGES-1].wr;
   assign wb_addr = st_ff[STAGES-1].addr;
   assign wb_w    = res_w;
   assign wb_m    = res_m;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff         <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         for (int k = 0; k < STAGES; k++) begin
            if (adv[k]) begin
               v_ff[k] <= v_in[k];
            end
         end
         if (adv[STAGES]) begin
            out_valid_ff <= v_ff[STAGES-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < STAGES; k++) begin
         if (adv[k]) begin
            st_ff[k] <= st_in[k];
         end
      end
      if (adv[STAGES]) begin
         out_w_ff <= res_w;
         out_m_ff <= res_m;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_w     = out_w_ff;
   assign out_m     = out_m_ff;

endmodule

// ===== design/momentum_weight_updater.sv =====
// An accepted item passes the memory read, the pipeline stages and the output register.
// Throughput: one item per cycle with rsp_ready high while items address different entries.
// An item whose entry is still pending a load or update in the pipeline waits
// until that write reaches the memories.
// Reset clears the pipeline and sets the registers to their defaults; the memories
// are not cleared and hold unknown values until loaded.
`timescale 1ns / 1ps

module momentum_weight_updater #(
   parameter int unsigned LAYERS    = 8,
   parameter int unsigned NEURONS   = 64,
   parameter int unsigned FRAC_BITS = 24,
   localparam int unsigned LW = (LAYERS > 1) ? $clog2(LAYERS) : 1,
   localparam int unsigned NW = (NEURONS > 1) ? $clog2(NEURONS) : 1
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [mwu_pkg::CMD_W-1:0]           req_command,
   input  logic [LW-1:0]                       req_layer,
   input  logic [NW-1:0]                       req_neuron,
   input  logic signed [mwu_pkg::DATA_W-1:0]   req_error_term,
   input  logic signed [mwu_pkg::DATA_W-1:0]   req_slope,
   input  logic signed [mwu_pkg::DATA_W-1:0]   req_upstream_activation,
   input  logic signed [mwu_pkg::DATA_W-1:0]   req_load_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [mwu_pkg::DATA_W-1:0]   rsp_weight_out,
   output logic signed [mwu_pkg::DATA_W-1:0]   rsp_momentum_out,
   input  logic                                csr_write,
   input  logic [mwu_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mwu_pkg::CSR_DATA_W-1:0]      csr_data
);

   import mwu_pkg::*;

   localparam int unsigned DEPTH = LAYERS * NEURONS;
   localparam int unsigned AW    = $clog2(DEPTH);

   cfg_type             cfg_ff;
   cmd_type             cmd;
   logic                in_range;
   logic                wr;
   logic                accept;
   logic [AW-1:0]       req_addr;
   logic                space;
   logic                hit;
   logic                wb_en;
   logic [AW-1:0]       wb_addr;
   logic signed [DATA_W-1:0] wb_w;
   logic signed [DATA_W-1:0] wb_m;
   logic signed [DATA_W-1:0] rd_w;
   logic signed [DATA_W-1:0] rd_m;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.learn_rate    <= LR_RESET;
         cfg_ff.momentum_rate <= VR_RESET;
         cfg_ff.update_mode   <= MODE_PLAIN;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_LEARN_RATE:    cfg_ff.learn_rate    <= csr_data[LR_W-1:0];
            CSR_MOMENTUM_RATE: cfg_ff.momentum_rate <= csr_data[VR_W-1:0];
            CSR_UPDATE_MODE:   cfg_ff.update_mode   <= mode_type'(csr_data[MODE_W-1:0]);
            default: begin
            end
         endcase
      end
   end

   assign cmd      = cmd_type'(req_command);
   assign in_range = (int'(req_layer) < LAYERS) && (int'(req_neuron) < NEURONS);
   assign req_addr = AW'(int'(req_layer) * NEURONS + int'(req_neuron));
   assign wr       = in_range && ((cmd == CMD_LOAD) || (cmd == CMD_UPDATE));

   assign req_ready = space && !hit;
   assign accept    = req_valid && req_ready;

   mwu_ram #(
      .DEPTH (DEPTH),
      .WIDTH (DATA_W)
   ) u_weight_ram (
      .clock   (clock),
      .wr_en   (wb_en),
      .wr_addr (wb_addr),
      .wr_data (wb_w),
      .rd_en   (accept),
      .rd_addr (req_addr),
      .rd_data (rd_w)
   );

   mwu_ram #(
      .DEPTH (DEPTH),
      .WIDTH (DATA_W)
   ) u_momentum_ram (
      .clock   (clock),
      .wr_en   (wb_en),
      .wr_addr (wb_addr),
      .wr_data (wb_m),
      .rd_en   (accept),
      .rd_addr (req_addr),
      .rd_data (rd_m)
   );

   mwu_pipe #(
      .AW        (AW),
      .FRAC_BITS (FRAC_BITS)
   ) u_pipe (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_load    (accept),
      .in_cmd     (cmd),
      .in_wr      (wr),
      .in_oor     (!in_range),
      .in_addr    (req_addr),
      .in_e       (req_error_term),
      .in_s       (req_slope),
      .in_a       (req_upstream_activation),
      .in_lv      (req_load_value),
      .rd_w       (rd_w),
      .rd_m       (rd_m),
      .probe_addr (req_addr),
      .space      (space),
      .hit        (hit),
      .wb_en      (wb_en),
      .wb_addr    (wb_addr),
      .wb_w       (wb_w),
      .wb_m       (wb_m),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_w      (rsp_weight_out),
      .out_m      (rsp_momentum_out)
   );

endmodule

// ===== design/mwu_checker.sv =====
`timescale 1ns / 1ps

module mwu_checker #(
   parameter int unsigned LAYERS  = 8,
   parameter int unsigned NEURONS = 64,
   localparam int unsigned LW = (LAYERS > 1) ? $clog2(LAYERS) : 1,
   localparam int unsigned NW = (NEURONS > 1) ? $clog2(NEURONS) : 1
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic [mwu_pkg::CMD_W-1:0]         req_command,
   input logic [LW-1:0]                     req_layer,
   input logic [NW-1:0]                     req_neuron,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [mwu_pkg::DATA_W-1:0] rsp_weight_out,
   input logic signed [mwu_pkg::DATA_W-1:0] rsp_momentum_out
);

   import mwu_pkg::*;

   logic req_acc;
   logic req_in_range;
   logic req_writes;

   assign req_acc      = req_valid && req_ready;
   assign req_in_range = (int'(req_layer) < LAYERS) && (int'(req_neuron) < NEURONS);
   assign req_writes   = req_in_range &&
                         ((req_command == CMD_LOAD) || (req_command == CMD_UPDATE));

   a_rsp_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped while stalled");

   a_rsp_data_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_weight_out) && $stable(rsp_momentum_out))
      else $error("result item changed while stalled");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result item present after reset");

   a_entry_interlock: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_writes |=>
         !(req_acc && (req_layer == $past(req_layer)) && (req_neuron == $past(req_neuron))))
      else $error("item taken while its entry is still pending a write");

endmodule

bind momentum_weight_updater mwu_checker #(
   .LAYERS  (LAYERS),
   .NEURONS (NEURONS)
) u_mwu_checker (.*);
